[hw/rtl/rbrs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Ring buffer region splitter package
// Shared widths, register indexes, reset values, payload structs and the
// controller state and command types.
// ----------------------------------------------------------------------------
package rbrs_pkg;

    localparam int unsigned OFS_W     = 32;  // free-running byte offsets
    localparam int unsigned RING_W    = 24;  // masked ring offset
    localparam int unsigned LEN_W     = 25;  // byte counts up to 2^24
    localparam int unsigned FRM_W     = 16;  // frame counts
    localparam int unsigned FB_W      = 6;   // frame size in bytes
    localparam int unsigned CL_W      = 5;   // capacity log2
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned CFG_W     = 16;  // widest configuration register
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned CAP_LOG2_MIN = 4;
    localparam int unsigned CAP_LOG2_MAX = 24;
    localparam int unsigned FRAME_MAX    = 32;

    // One quotient bit per divider step.
    localparam int unsigned DIV_STEPS = LEN_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_CAP_LOG2      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_FRAMES = 2'd2;

    localparam logic [CL_W-1:0]  RST_CAP_LOG2      = 5'd18;
    localparam logic [FB_W-1:0]  RST_FRAME_BYTES   = 6'd8;
    localparam logic [FRM_W-1:0] RST_DEVICE_FRAMES = 16'd480;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESERVE = 2'd0,
        CMD_COMMIT  = 2'd1,
        CMD_DRAIN   = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [LEN_W-1:0] byte_count;
        logic [FRM_W-1:0] padding_frames;
    } t_req;

    typedef struct packed {
        logic [RING_W-1:0] region_one_offset;
        logic [LEN_W-1:0]  region_one_bytes;
        logic [LEN_W-1:0]  region_two_bytes;
        logic [FRM_W-1:0]  frames_moved;
        logic [LEN_W-1:0]  backlog_bytes;
        logic [LEN_W-1:0]  free_bytes;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SNAP,
        S_PREP,
        S_DIV,
        S_CLIP,
        S_MUL,
        S_SPLIT
    } t_state;

    typedef struct packed {
        logic load;
        logic snap;
        logic prep;
        logic div_step;
        logic clip;
        logic mul;
        logic finish;
    } t_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic div_last;
    } t_stat;

endpackage
`default_nettype wire

[hw/rtl/rbrs_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Ring buffer region splitter datapath
// Holds the offsets, configuration and request, the serial divider and the
// region split logic, and registers the result.
// ----------------------------------------------------------------------------
module rbrs_datapath (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  rbrs_pkg::t_ctrl                     i_ctrl,
    output rbrs_pkg::t_stat                     o_stat,
    input  rbrs_pkg::t_req                      i_req,
    input  wire                                 i_cfg_we,
    input  wire  [rbrs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [rbrs_pkg::CFG_W-1:0]          i_cfg_wdata,
    output rbrs_pkg::t_rsp                      o_rsp,
    output logic                                o_done
);

    localparam int unsigned OFS_W  = rbrs_pkg::OFS_W;
    localparam int unsigned RING_W = rbrs_pkg::RING_W;
    localparam int unsigned LEN_W  = rbrs_pkg::LEN_W;
    localparam int unsigned FRM_W  = rbrs_pkg::FRM_W;
    localparam int unsigned FB_W   = rbrs_pkg::FB_W;
    localparam int unsigned CL_W   = rbrs_pkg::CL_W;
    localparam int unsigned CNT_W  = rbrs_pkg::DIV_CNT_W;

    // Configuration and offsets.
    logic [CL_W-1:0]  r_cap_log2;
    logic [FB_W-1:0]  r_frame_bytes;
    logic [FRM_W-1:0] r_dev_frames;
    logic [OFS_W-1:0] r_wr;
    logic [OFS_W-1:0] r_rd;
    logic             r_done;

    // Request and working registers.
    rbrs_pkg::t_cmd   r_cmd;
    logic [LEN_W-1:0] r_count;
    logic [FRM_W-1:0] r_pad;
    logic [LEN_W-1:0] r_backlog;
    logic [LEN_W-1:0] r_free;
    logic [LEN_W-1:0] r_len;
    logic [FRM_W-1:0] r_devfree;
    logic [LEN_W-1:0] r_quo;
    logic [FB_W-1:0]  r_rem;
    logic [CNT_W-1:0] r_div_cnt;
    logic [FRM_W-1:0] r_use;
    rbrs_pkg::t_rsp   r_rsp;

    logic [CL_W-1:0]        eff_log2;
    logic [FB_W-1:0]        eff_fb;
    logic [LEN_W-1:0]       cap;
    logic [RING_W-1:0]      mask;
    logic [OFS_W-1:0]       diff;
    logic [LEN_W-1:0]       n_backlog;
    logic [FB_W:0]          trial;
    logic                   ge;
    logic [FB_W-1:0]        n_rem;
    logic [FRM_W+FB_W-1:0]  prod;
    logic                   is_drain;
    logic                   is_none;
    logic [RING_W-1:0]      off;
    logic [LEN_W-1:0]       len_eff;
    logic [LEN_W:0]         end_sum;
    logic                   wrap;
    logic [LEN_W-1:0]       r1;
    logic [LEN_W-1:0]       r2;

    // Out-of-range settings are clamped to the nearest legal value.
    always_comb begin
        eff_log2 = r_cap_log2;
        if (r_cap_log2 < CL_W'(rbrs_pkg::CAP_LOG2_MIN)) begin
            eff_log2 = CL_W'(rbrs_pkg::CAP_LOG2_MIN);
        end else if (r_cap_log2 > CL_W'(rbrs_pkg::CAP_LOG2_MAX)) begin
            eff_log2 = CL_W'(rbrs_pkg::CAP_LOG2_MAX);
        end
        eff_fb = r_frame_bytes;
        if (r_frame_bytes == '0) begin
            eff_fb = FB_W'(1);
        end else if (r_frame_bytes > FB_W'(rbrs_pkg::FRAME_MAX)) begin
            eff_fb = FB_W'(rbrs_pkg::FRAME_MAX);
        end
    end

    assign cap  = LEN_W'(1) << eff_log2;
    assign mask = RING_W'(cap - LEN_W'(1));

    // Backlog saturates at the capacity.
    assign diff      = r_wr - r_rd;
    assign n_backlog = (diff > OFS_W'(cap)) ? cap : diff[LEN_W-1:0];

    // Restoring divide of the backlog by the frame size, one bit per step.
    assign trial = {r_rem, r_quo[LEN_W-1]};
    assign ge    = (trial >= {1'b0, eff_fb});
    assign n_rem = ge ? FB_W'(trial - {1'b0, eff_fb}) : trial[FB_W-1:0];

    assign prod = r_use * eff_fb;

    // Region split.
    assign is_drain = (r_cmd == rbrs_pkg::CMD_DRAIN);
    assign is_none  = (r_cmd == rbrs_pkg::CMD_NONE);
    assign off      = is_none ? '0
                    : ((is_drain ? r_rd[RING_W-1:0] : r_wr[RING_W-1:0]) & mask);
    assign len_eff  = is_none ? '0 : r_len;
    assign end_sum  = {2'b00, off} + {1'b0, len_eff};
    assign wrap     = (end_sum > {1'b0, cap});
    assign r1       = wrap ? (cap - {1'b0, off}) : len_eff;
    assign r2       = wrap ? (len_eff - r1) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_log2    <= rbrs_pkg::RST_CAP_LOG2;
            r_frame_bytes <= rbrs_pkg::RST_FRAME_BYTES;
            r_dev_frames  <= rbrs_pkg::RST_DEVICE_FRAMES;
            r_wr          <= '0;
            r_rd          <= '0;
            r_done        <= 1'b0;
        end else begin
            r_done <= i_ctrl.finish;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rbrs_pkg::CFG_CAP_LOG2:      r_cap_log2    <= i_cfg_wdata[CL_W-1:0];
                    rbrs_pkg::CFG_FRAME_BYTES:   r_frame_bytes <= i_cfg_wdata[FB_W-1:0];
                    rbrs_pkg::CFG_DEVICE_FRAMES: r_dev_frames  <= i_cfg_wdata[FRM_W-1:0];
                    default: ;
                endcase
            end
            if (i_ctrl.finish) begin
                if (r_cmd == rbrs_pkg::CMD_COMMIT) begin
                    r_wr <= r_wr + OFS_W'(len_eff);
                end
                if (is_drain) begin
                    r_rd <= r_rd + OFS_W'(len_eff);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd   <= rbrs_pkg::t_cmd'(i_req.command);
            r_count <= i_req.byte_count;
            r_pad   <= i_req.padding_frames;
        end
        if (i_ctrl.snap) begin
            r_backlog <= n_backlog;
            r_free    <= cap - n_backlog;
        end
        if (i_ctrl.prep) begin
            r_len     <= (r_count > r_free) ? r_free : r_count;
            r_devfree <= (r_dev_frames > r_pad) ? (r_dev_frames - r_pad) : '0;
            r_quo     <= r_backlog;
            r_rem     <= '0;
            r_div_cnt <= CNT_W'(rbrs_pkg::DIV_STEPS - 1);
        end
        if (i_ctrl.div_step) begin
            r_quo     <= {r_quo[LEN_W-2:0], ge};
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt - CNT_W'(1);
        end
        if (i_ctrl.clip) begin
            r_use <= (r_quo > LEN_W'(r_devfree)) ? r_devfree : r_quo[FRM_W-1:0];
        end
        if (i_ctrl.mul) begin
            r_len <= LEN_W'(prod);
        end
        if (i_ctrl.finish) begin
            r_rsp.region_one_offset <= off;
            r_rsp.region_one_bytes  <= r1;
            r_rsp.region_two_bytes  <= r2;
            r_rsp.frames_moved      <= is_drain ? r_use : '0;
            r_rsp.backlog_bytes     <= r_backlog;
            r_rsp.free_bytes        <= r_free;
        end
    end

    assign o_stat.cmd      = r_cmd;
    assign o_stat.div_last = (r_div_cnt == '0);
    assign o_rsp           = r_rsp;
    assign o_done          = r_done;

`ifndef SYNTHESIS
    // Backlog and free space always add up to the ring size.
    a_snap_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.snap |=> ({1'b0, r_backlog} + {1'b0, r_free}) == {1'b0, $past(cap)})
        else $error("backlog plus free space differs from capacity");

    // The two regions together cover exactly the split length.
    a_split_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.finish |=> ({1'b0, r_rsp.region_one_bytes} + {1'b0, r_rsp.region_two_bytes})
                          == {1'b0, $past(len_eff)})
        else $error("region lengths do not add up to the split length");
`endif

endmodule
`default_nettype wire

[hw/rtl/rbrs_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Ring buffer region splitter controller
// Sequences snapshot, length preparation, the divider loop, clip and multiply for
// drains and the final region split.
// ----------------------------------------------------------------------------
module rbrs_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    output logic                 o_busy,
    input  rbrs_pkg::t_stat      i_stat,
    output rbrs_pkg::t_ctrl      o_ctrl
);

    rbrs_pkg::t_state r_state;
    rbrs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbrs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            rbrs_pkg::S_IDLE: begin
                if (i_start) begin
                    o_ctrl.load = 1'b1;
                    n_state     = rbrs_pkg::S_SNAP;
                end
            end
            rbrs_pkg::S_SNAP: begin
                o_ctrl.snap = 1'b1;
                n_state     = rbrs_pkg::S_PREP;
            end
            rbrs_pkg::S_PREP: begin
                o_ctrl.prep = 1'b1;
                n_state     = (i_stat.cmd == rbrs_pkg::CMD_DRAIN) ? rbrs_pkg::S_DIV
                                                                  : rbrs_pkg::S_SPLIT;
            end
            rbrs_pkg::S_DIV: begin
                o_ctrl.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = rbrs_pkg::S_CLIP;
                end
            end
            rbrs_pkg::S_CLIP: begin
                o_ctrl.clip = 1'b1;
                n_state     = rbrs_pkg::S_MUL;
            end
            rbrs_pkg::S_MUL: begin
                o_ctrl.mul = 1'b1;
                n_state    = rbrs_pkg::S_SPLIT;
            end
            rbrs_pkg::S_SPLIT: begin
                o_ctrl.finish = 1'b1;
                n_state       = rbrs_pkg::S_IDLE;
            end
            default: begin
                n_state = rbrs_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != rbrs_pkg::S_IDLE);

`ifndef SYNTHESIS
    // Only a drain enters the divider loop.
    a_div_only_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rbrs_pkg::S_PREP && i_stat.cmd != rbrs_pkg::CMD_DRAIN)
        |=> r_state == rbrs_pkg::S_SPLIT)
        else $error("non-drain request entered the divider");
`endif

endmodule
`default_nettype wire

[hw/rtl/ring_buffer_region_splitter.sv]
`default_nettype none
// Reserve, commit and the unused command pass through snapshot, preparation and split;
// a drain adds the bit-serial divider loop, clip and multiply before the split.
// Throughput: one request at a time; busy drops in the cycle the done strobe is shown,
// so the next request may start then. The receiver cannot stall the result.
// Reset is synchronous and active low: offsets clear to zero and the registers
// return to capacity_log2 18, frame_bytes 8 and device_frames 480.
// ----------------------------------------------------------------------------
// Ring buffer region splitter
// Pointer manager for a power-of-two byte ring. It tracks free-running write
// and read offsets and, for each request, reports the region (or the two
// regions, when the span wraps) that a reserve, commit or drain covers,
// together with the backlog and free space seen before the request.
// ----------------------------------------------------------------------------
module ring_buffer_region_splitter (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // Request channel: accepted when start is high and busy is low.
    input  wire                             start,
    output logic                            busy,
    input  rbrs_pkg::t_req                  i_req,
    // Result channel: valid for exactly one cycle while o_done is high.
    output logic                            o_done,
    output rbrs_pkg::t_rsp                  o_rsp,
    // Configuration write port, to be used only while the block is idle (the block does not enforce this).
    input  wire                             i_cfg_we,
    input  wire  [rbrs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [rbrs_pkg::CFG_W-1:0]      i_cfg_wdata
);

    // The controller sequences the work; the datapath holds every register
    // that carries data, including the configuration and both offsets.
    rbrs_pkg::t_ctrl ctrl;
    rbrs_pkg::t_stat stat;

    rbrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // A drain divides the backlog by the frame size one quotient bit per
    // cycle, then clips to the free device frames and scales back to bytes.
    rbrs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp       (o_rsp),
        .o_done      (o_done)
    );

`ifndef SYNTHESIS
    // Every request ends with exactly one result strobe as busy drops.
    a_done_on_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result strobe");
`endif

endmodule
`default_nettype wire

[sim/rbrs_region_check.sv]
// ----------------------------------------------------------------------------
// Ring region checker
// Watches the request, result and register-write channels of the ring buffer
// region splitter, keeps its own copy of the ring offsets and registers, works
// out the regions each accepted request should report and compares every
// result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rbrs_region_check import rbrs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_req                 i_req,
    input  logic                 i_done,
    input  t_rsp                 i_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output int                   o_pending,
    output int                   o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CL_W-1:0]  cap_log2;
    logic [FB_W-1:0]  frame_sz;
    logic [FRM_W-1:0] dev_frames;
    logic [OFS_W-1:0] wr_ofs;
    logic [OFS_W-1:0] rd_ofs;
    t_rsp             pending_regions[$];
    t_rsp             head_rsp;
    int               mismatch_cnt = 0;

    // Works out the result of one request and moves the offsets as the
    // block does. Backlog and free space are taken before the request.
    function automatic t_rsp predict_regions(t_req req);
        logic [OFS_W-1:0] cap;
        logic [OFS_W-1:0] backlog;
        logic [OFS_W-1:0] free_b;
        logic [OFS_W-1:0] cnt;
        logic [OFS_W-1:0] off;
        logic [OFS_W-1:0] span;
        logic [OFS_W-1:0] fb;
        logic [OFS_W-1:0] dev_free;
        logic [OFS_W-1:0] whole;
        logic [OFS_W-1:0] frames;
        logic [OFS_W-1:0] r1;
        logic [OFS_W-1:0] r2;
        int unsigned      cl;
        t_rsp             rsp;
        cl = 32'(cap_log2);
        if (cl < CAP_LOG2_MIN) cl = CAP_LOG2_MIN;
        if (cl > CAP_LOG2_MAX) cl = CAP_LOG2_MAX;
        cap = 32'd1 << cl;
        // A backlog above the capacity (capacity lowered) saturates.
        backlog = wr_ofs - rd_ofs;
        if (backlog > cap) backlog = cap;
        free_b = cap - backlog;
        cnt    = OFS_W'(req.byte_count);
        off    = '0;
        span   = '0;
        frames = '0;
        case (t_cmd'(req.command))
            CMD_RESERVE: begin
                span = (cnt > free_b) ? free_b : cnt;
                off  = wr_ofs & (cap - 32'd1);
            end
            CMD_COMMIT: begin
                span   = (cnt > free_b) ? free_b : cnt;
                off    = wr_ofs & (cap - 32'd1);
                wr_ofs = wr_ofs + span;
            end
            CMD_DRAIN: begin
                fb = OFS_W'(frame_sz);
                if (fb == '0) fb = 32'd1;
                if (fb > FRAME_MAX) fb = FRAME_MAX;
                if (dev_frames > req.padding_frames) begin
                    dev_free = OFS_W'(dev_frames - req.padding_frames);
                end else begin
                    dev_free = '0;
                end
                whole  = backlog / fb;
                frames = (whole < dev_free) ? whole : dev_free;
                span   = frames * fb;
                off    = rd_ofs & (cap - 32'd1);
                rd_ofs = rd_ofs + span;
            end
            default: begin
            end
        endcase
        if (off + span > cap) begin
            r1 = cap - off;
            r2 = span - r1;
        end else begin
            r1 = span;
            r2 = '0;
        end
        rsp.region_one_offset = off[RING_W-1:0];
        rsp.region_one_bytes  = r1[LEN_W-1:0];
        rsp.region_two_bytes  = r2[LEN_W-1:0];
        rsp.frames_moved      = frames[FRM_W-1:0];
        rsp.backlog_bytes     = backlog[LEN_W-1:0];
        rsp.free_bytes        = free_b[LEN_W-1:0];
        return rsp;
    endfunction

    function automatic string fmt_rsp(t_rsp r);
        return $sformatf("ofs=%h r1=%h r2=%h frames=%h backlog=%h free=%h",
                         r.region_one_offset, r.region_one_bytes, r.region_two_bytes,
                         r.frames_moved, r.backlog_bytes, r.free_bytes);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cap_log2   = RST_CAP_LOG2;
            frame_sz   = RST_FRAME_BYTES;
            dev_frames = RST_DEVICE_FRAMES;
            wr_ofs     = '0;
            rd_ofs     = '0;
            pending_regions.delete();
        end else begin
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_index)
                    CFG_CAP_LOG2:      cap_log2   = i_cfg_wdata[CL_W-1:0];
                    CFG_FRAME_BYTES:   frame_sz   = i_cfg_wdata[FB_W-1:0];
                    CFG_DEVICE_FRAMES: dev_frames = i_cfg_wdata[FRM_W-1:0];
                    default: begin
                    end
                endcase
            end
            // The result of one request may leave in the same cycle the next
            // request is taken, so results are matched before new predictions.
            if (i_done === 1'b1) begin
                if (pending_regions.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("ERROR %0t: result with no request outstanding: %s",
                                 $realtime, fmt_rsp(i_rsp));
                    end
                end else begin
                    head_rsp = pending_regions.pop_front();
                    if (i_rsp !== head_rsp) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("ERROR %0t: result mismatch", $realtime);
                            $display("  expected %s", fmt_rsp(head_rsp));
                            $display("  actual   %s", fmt_rsp(i_rsp));
                        end
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                pending_regions.push_back(predict_regions(i_req));
            end
        end
        o_pending <= pending_regions.size();
        o_errors  <= mismatch_cnt;
    end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Ring buffer region splitter testbench
// Drives reserve, commit and drain requests into the region splitter under a
// series of ring, frame and device settings, with and without gaps between
// requests. A checker beside the block predicts every result and counts the
// failures; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rbrs_pkg::*;

    // The slowest correct run is roughly 850 drains plus idle gaps between
    // requests; the limit leaves a wide margin.
    localparam int unsigned CYCLE_LIMIT   = 400000;
    // Longest request latency (a drain) with some slack, used for the tail.
    localparam int unsigned DRAIN_LATENCY = 40;
    localparam int unsigned N_PHASES      = 9;
    localparam int unsigned PHASE_REQS    = 92;
    // Register index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_req                 i_req       = '0;
    logic                 o_done;
    t_rsp                 o_rsp;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    int                   pending_cnt;
    int                   error_cnt;
    int unsigned          cycle_cnt   = 0;

    // Stimulus shaping only: the ring size and device size currently set, so
    // that request sizes land near the interesting boundaries, and the share
    // of cycles in which the sender holds back.
    logic [OFS_W-1:0]     ring_bytes  = 32'd1 << RST_CAP_LOG2;
    logic [FRM_W-1:0]     dev_size    = RST_DEVICE_FRAMES;
    int unsigned          idle_pct    = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    ring_buffer_region_splitter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    rbrs_region_check i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_req       (i_req),
        .i_done      (o_done),
        .i_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_pending   (pending_cnt),
        .o_errors    (error_cnt)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Presents one request and holds it until the block takes it, i.e. until
    // an edge at which busy is low. Start stays high afterwards unless the
    // sender decides to idle, so back-to-back requests need no toggle.
    task automatic send_request(input t_cmd cmd, input logic [LEN_W-1:0] cnt,
                                input logic [FRM_W-1:0] pad);
        t_req        req;
        int unsigned gap;
        req.command        = cmd;
        req.byte_count     = cnt;
        req.padding_frames = pad;
        i_req <= req;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drops start and waits until every predicted result has come back and
    // the block is idle. The first edge lets the checker count the request
    // taken at the current edge.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    // Writes all three registers back to back while the block is idle, and
    // optionally pokes the unused index as well.
    task automatic configure(input logic [CFG_W-1:0] cap_w, input logic [CFG_W-1:0] fb_w,
                             input logic [CFG_W-1:0] dev_w, input logic poke_unused);
        int unsigned cl;
        settle();
        cl = 32'(cap_w[CL_W-1:0]);
        if (cl < CAP_LOG2_MIN) cl = CAP_LOG2_MIN;
        if (cl > CAP_LOG2_MAX) cl = CAP_LOG2_MAX;
        ring_bytes = 32'd1 << cl;
        dev_size   = dev_w[FRM_W-1:0];
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CAP_LOG2;
        i_cfg_wdata <= cap_w;
        @(posedge i_clk);
        i_cfg_index <= CFG_FRAME_BYTES;
        i_cfg_wdata <= fb_w;
        @(posedge i_clk);
        i_cfg_index <= CFG_DEVICE_FRAMES;
        i_cfg_wdata <= dev_w;
        @(posedge i_clk);
        if (poke_unused) begin
            i_cfg_index <= CFG_UNUSED;
            i_cfg_wdata <= '1;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // One random request. Byte counts cluster around the ring size so that
    // clamping to the free space and wrapping both happen often; padding
    // mostly stays below the device size so that drains actually move frames.
    task automatic send_random();
        int unsigned      pick;
        t_cmd             cmd;
        logic [31:0]      c32;
        logic [31:0]      p32;
        pick = $urandom_range(0, 99);
        if (pick < 25) cmd = CMD_RESERVE;
        else if (pick < 60) cmd = CMD_COMMIT;
        else if (pick < 95) cmd = CMD_DRAIN;
        else cmd = CMD_NONE;
        pick = $urandom_range(0, 99);
        if (pick < 55) c32 = $urandom_range(0, ring_bytes);
        else if (pick < 70) c32 = $urandom_range(0, ring_bytes >> 3);
        else if (pick < 85) c32 = $urandom;
        else if (pick < 92) c32 = ring_bytes;
        else if (pick < 96) c32 = 32'h01FF_FFFF;
        else c32 = '0;
        pick = $urandom_range(0, 99);
        if (pick < 50) p32 = $urandom_range(0, dev_size);
        else if (pick < 65) p32 = $urandom_range(0, dev_size >> 2);
        else if (pick < 80) p32 = $urandom;
        else if (pick < 90) p32 = {16'd0, dev_size};
        else p32 = 32'h0000_FFFF;
        send_request(cmd, c32[LEN_W-1:0], p32[FRM_W-1:0]);
    endtask

    initial begin
        logic [31:0] rc;
        logic [31:0] rf;
        logic [31:0] rd;

        // Synchronous reset, once, at the start of the run.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset settings (2^18-byte ring, 8-byte
        // frames, 480-frame device).
        send_request(CMD_RESERVE, 25'd0, 16'd0);
        // Requests above the free space clamp to it.
        send_request(CMD_RESERVE, 25'h100_0000, 16'd0);
        send_request(CMD_RESERVE, 25'h1FF_FFFF, 16'hFFFF);
        send_request(CMD_COMMIT, 25'd1000, 16'd0);
        // Drains everything: 125 whole frames.
        send_request(CMD_DRAIN, 25'd0, 16'd0);
        // Fills the ring from offset 1000, so the commit wraps past the end.
        send_request(CMD_COMMIT, 25'h1FF_FFFF, 16'd0);
        // Ring full: nothing left to reserve or commit.
        send_request(CMD_RESERVE, 25'd5, 16'd0);
        send_request(CMD_COMMIT, 25'd7, 16'd0);
        // Padding above the device size saturates the free device frames at
        // zero; padding equal to it gives zero too.
        send_request(CMD_DRAIN, 25'h1FF_FFFF, 16'hFFFF);
        send_request(CMD_DRAIN, 25'd0, 16'd480);
        send_request(CMD_DRAIN, 25'd0, 16'd479);
        send_request(CMD_DRAIN, 25'd0, 16'd0);
        send_request(CMD_DRAIN, 25'd0, 16'd0);
        // The unused command reports backlog and free space only.
        send_request(CMD_NONE, 25'h1FF_FFFF, 16'hFFFF);
        send_request(CMD_NONE, 25'd0, 16'd0);
        // A commit that is not a whole number of frames leaves a partial
        // frame behind the drain.
        send_request(CMD_COMMIT, 25'd13, 16'd0);
        send_request(CMD_RESERVE, 25'h1FF_FFFF, 16'd0);
        send_request(CMD_DRAIN, 25'd0, 16'd0);

        // Random phases. Each phase after the first rewrites the registers;
        // the first change shrinks the ring under a large backlog, which
        // exercises the backlog saturation. Idling cycles through none, 49
        // in a hundred, none and 15 in a hundred.
        for (int unsigned p = 0; p < N_PHASES; p++) begin
            case (p)
                1: configure(16'd4, 16'd1, 16'd1, 1'b0);
                2: configure(16'd24, 16'd32, 16'hFFFF, 1'b0);
                // Out-of-range settings: capacity acts as 16 bytes, frame as 1.
                3: configure(16'd0, 16'd0, 16'd0, 1'b0);
                // All data bits set: capacity acts as 2^24, frame as 32.
                4: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
                5: configure(16'd6, 16'd3, 16'd20, 1'b0);
                6: configure(16'd25, 16'd33, 16'd7, 1'b1);
                7: begin
                    rc = $urandom_range(4, 12);
                    rf = $urandom_range(1, 32);
                    rd = $urandom_range(1, 600);
                    configure(rc[CFG_W-1:0], rf[CFG_W-1:0], rd[CFG_W-1:0], 1'b0);
                end
                8: configure(16'd18, 16'd8, 16'd480, 1'b0);
                default: begin
                end
            endcase
            case (p % 4)
                1: idle_pct = 49;
                3: idle_pct = 15;
                default: idle_pct = 0;
            endcase
            repeat (PHASE_REQS) send_random();
        end

        // Let every outstanding result arrive, then give a stray strobe time
        // to show up before the verdict.
        settle();
        repeat (DRAIN_LATENCY) @(posedge i_clk);
        if (error_cnt == 0 && pending_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/rbrs_pkg.sv
hw/rtl/rbrs_datapath.sv
hw/rtl/rbrs_ctrl.sv
hw/rtl/ring_buffer_region_splitter.sv
sim/rbrs_region_check.sv
sim/testbench.sv
